>>> rtl/rc4_keystream_generator_core_defines.svh
// Assertion macros for the RC4 keystream generator checker.
// Depends on nothing; included by the checker file.
`ifndef RC4_KEYSTREAM_GENERATOR_CORE_DEFINES_SVH
`define RC4_KEYSTREAM_GENERATOR_CORE_DEFINES_SVH

// Clocked assertion, off while reset is asserted.
`define RC4_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define RC4_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/rc4_pkg.sv
// Shared constants and the sequencer state type of the RC4 keystream generator.
// Depends on nothing.
package rc4_pkg;

	localparam int BYTE_W      = 8;
	localparam int PERM_DEPTH  = 256;
	localparam int KEY_MAX_DEF = 256;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GEN1,
		ST_GEN2,
		ST_GEN3,
		ST_KS0,
		ST_KS1,
		ST_KS2,
		ST_KS3
	} rc4_state_t;

endpackage

>>> rtl/rc4_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// Read during write to the same address returns the old contents.
module rc4_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/rc4_keystream_generator_core.sv
// RC4 keystream generator top level: key loading, key scheduling and byte generation.
// Depends on rc4_pkg and rc4_ram.
//
//  channel | valid     | stall     | word fields
//  --------+-----------+-----------+------------------------------
//  request | req_valid | req_stall | mode, key_byte, key_last
//  result  | ks_valid  | ks_stall  | keystream_byte
//
// Generate words step through ST_GEN1 to ST_GEN3, a read-swap-read chain on the
// permutation RAM (one read port, one write port); the next is taken in ST_GEN3 if
// the output queue has room. Load words go back to back; one with key_last starts key
// scheduling (ST_KS0, then ST_KS1 to ST_KS3 per swap step), with req_stall high.
// Reset needs no clearing pass; per-entry valid bits give the identity permutation.
// A two-word output queue lets generation continue while ks_stall is high.
module rc4_keystream_generator_core #(
	parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	output logic                      req_stall,
	input  logic                      mode,
	input  logic [rc4_pkg::BYTE_W-1:0] key_byte,
	input  logic                      key_last,
	output logic                      ks_valid,
	input  logic                      ks_stall,
	output logic [rc4_pkg::BYTE_W-1:0] keystream_byte
);
	import rc4_pkg::*;

	localparam int KAW = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;
	localparam int KLW = $clog2(KEY_MAX + 1);

	rc4_state_t state_q, state_d;

	logic [BYTE_W-1:0]     i_q, j_q, n_q, acc_q;
	logic [KLW-1:0]        key_len_q, len_q;
	logic [KAW-1:0]        kpos_q;
	logic [PERM_DEPTH-1:0] vld_q;
	logic                  out_v_q, skid_v_q;
	logic [BYTE_W-1:0]     ks_q, skid_q;

	logic [BYTE_W-1:0] si_q, sn_q, t_q;
	logic              byp_hit_q, rvld_q;
	logic [BYTE_W-1:0] byp_d_q, raddr_q;

	logic              accept, gen_acc, load_acc, sched_start;
	logic              key_room, room, push, pop;
	logic [KLW-1:0]    klen_new, kpos_inc;
	logic [BYTE_W-1:0] ram_rd, key_rd, perm_rd, j_new, t_new, acc_next, res;
	logic              perm_we;
	logic [BYTE_W-1:0] perm_waddr, perm_wdata, perm_raddr;

	assign accept      = req_valid && !req_stall;
	assign gen_acc     = accept && mode;
	assign load_acc    = accept && !mode;
	assign sched_start = load_acc && key_last;

	assign key_room = key_len_q < KLW'(KEY_MAX);
	assign klen_new = key_room ? key_len_q + KLW'(1) : key_len_q;
	assign kpos_inc = KLW'(kpos_q) + KLW'(1);

	assign perm_rd  = byp_hit_q ? byp_d_q : (rvld_q ? ram_rd : raddr_q);
	assign j_new    = j_q + perm_rd;
	assign t_new    = si_q + perm_rd;
	assign acc_next = acc_q + perm_rd + key_rd;

	assign room = (state_q == ST_IDLE) ? !(out_v_q && skid_v_q) : !(out_v_q || skid_v_q);
	assign req_stall = !(state_q inside {ST_IDLE, ST_GEN3}) || (mode && !room);

	assign pop            = out_v_q && !ks_stall;
	assign ks_valid       = out_v_q;
	assign keystream_byte = ks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		perm_we    = 1'b0;
		perm_waddr = '0;
		perm_wdata = '0;
		perm_raddr = '0;
		push       = 1'b0;
		res        = '0;
		case (state_q)
			ST_IDLE, ST_GEN3: begin
				if (state_q == ST_GEN3) begin
					perm_we    = 1'b1;
					perm_waddr = j_q;
					perm_wdata = si_q;
					push       = 1'b1;
					res        = (t_q == j_q) ? si_q : perm_rd;
				end
				state_d = ST_IDLE;
				if (gen_acc) begin
					perm_raddr = i_q + BYTE_W'(1);
					state_d    = ST_GEN1;
				end else if (sched_start) begin
					state_d = ST_KS0;
				end
			end
			ST_GEN1: begin
				perm_raddr = j_new;
				state_d    = ST_GEN2;
			end
			ST_GEN2: begin
				perm_we    = 1'b1;
				perm_waddr = i_q;
				perm_wdata = perm_rd;
				perm_raddr = t_new;
				state_d    = ST_GEN3;
			end
			ST_KS0: begin
				perm_raddr = n_q;
				state_d    = ST_KS1;
			end
			ST_KS1: begin
				perm_raddr = acc_next;
				state_d    = ST_KS2;
			end
			ST_KS2: begin
				perm_we    = 1'b1;
				perm_waddr = n_q;
				perm_wdata = perm_rd;
				state_d    = ST_KS3;
			end
			ST_KS3: begin
				perm_we    = 1'b1;
				perm_waddr = acc_q;
				perm_wdata = sn_q;
				if (n_q == '1) begin
					state_d = ST_IDLE;
				end else begin
					perm_raddr = n_q + BYTE_W'(1);
					state_d    = ST_KS1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q       <= '0;
			j_q       <= '0;
			n_q       <= '0;
			acc_q     <= '0;
			kpos_q    <= '0;
			key_len_q <= '0;
			len_q     <= KLW'(1);
			vld_q     <= '0;
			byp_hit_q <= 1'b0;
		end else begin
			byp_hit_q <= perm_we && (perm_waddr == perm_raddr);
			if (sched_start) begin
				vld_q <= '0;
			end else if (perm_we) begin
				vld_q[perm_waddr] <= 1'b1;
			end
			if (load_acc) begin
				key_len_q <= key_last ? '0 : klen_new;
			end
			if (sched_start) begin
				i_q    <= '0;
				j_q    <= '0;
				n_q    <= '0;
				acc_q  <= '0;
				kpos_q <= '0;
				len_q  <= (klen_new == '0) ? KLW'(1) : klen_new;
			end else begin
				if (gen_acc) begin
					i_q <= i_q + BYTE_W'(1);
				end
				if (state_q == ST_GEN1) begin
					j_q <= j_new;
				end
				if (state_q == ST_KS1) begin
					acc_q  <= acc_next;
					kpos_q <= (kpos_inc >= len_q) ? '0 : kpos_inc[KAW-1:0];
				end
				if (state_q == ST_KS3 && n_q != '1) begin
					n_q <= n_q + BYTE_W'(1);
				end
			end
		end
	end

	// output queue: ks_q is the visible word, skid_q the second entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q) begin
				skid_v_q <= push;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			if (out_v_q) begin
				skid_v_q <= 1'b1;
			end else begin
				out_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q) begin
				ks_q <= skid_q;
				if (push) begin
					skid_q <= res;
				end
			end else if (push) begin
				ks_q <= res;
			end
		end else if (push) begin
			if (out_v_q) begin
				skid_q <= res;
			end else begin
				ks_q <= res;
			end
		end
	end

	always_ff @(posedge clk) begin
		byp_d_q <= perm_wdata;
		raddr_q <= perm_raddr;
		rvld_q  <= vld_q[perm_raddr];
		if (state_q == ST_GEN1) begin
			si_q <= perm_rd;
		end
		if (state_q == ST_GEN2) begin
			t_q <= t_new;
		end
		if (state_q == ST_KS1) begin
			sn_q <= perm_rd;
		end
	end

	rc4_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(PERM_DEPTH)
	) u_perm_ram (
		.clk  (clk),
		.we   (perm_we),
		.waddr(perm_waddr),
		.wdata(perm_wdata),
		.raddr(perm_raddr),
		.rdata(ram_rd)
	);

	rc4_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(KEY_MAX)
	) u_key_ram (
		.clk  (clk),
		.we   (load_acc && key_room),
		.waddr(key_len_q[KAW-1:0]),
		.wdata(key_byte),
		.raddr(kpos_q),
		.rdata(key_rd)
	);

endmodule

>>> rtl/rc4_chk.sv
// Port-level checker for the RC4 keystream generator, bound to the top level.
// Depends on rc4_keystream_generator_core_defines.svh.
`include "rc4_keystream_generator_core_defines.svh"

module rc4_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_stall,
	input logic       mode,
	input logic       key_last,
	input logic       ks_valid,
	input logic       ks_stall,
	input logic [7:0] keystream_byte
);

	`RC4_ASSERT(a_ks_hold, clk, arst_n, ks_valid && ks_stall |=> ks_valid && $stable(keystream_byte), "stalled keystream word changed")
	`RC4_ASSERT(a_gen_busy, clk, arst_n, req_valid && !req_stall && mode |=> req_stall ##1 req_stall, "generate word accepted too early")
	`RC4_ASSERT(a_sched_busy, clk, arst_n, req_valid && !req_stall && !mode && key_last |=> req_stall ##1 req_stall ##1 req_stall, "request taken during key scheduling")
	`RC4_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |-> !ks_valid, "keystream word valid in reset")

endmodule

bind rc4_keystream_generator_core rc4_chk u_rc4_chk (.*);

>>> tb/rc4_keystream_generator_core_checker.sv
// Scoreboard for the RC4 keystream generator: mirrors the permutation, key store
// and generation indices, and checks every accepted keystream word in order.
// Depends on rc4_pkg; defines rc4_kg_tb_pkg, which the testbench top also uses.
`timescale 1ns / 100ps

package rc4_kg_tb_pkg;
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_GEN  = 1'b1;
endpackage

module rc4_keystream_generator_core_checker #(
	parameter int KEY_MAX = rc4_pkg::KEY_MAX_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_stall,
	input  logic                       mode,
	input  logic [rc4_pkg::BYTE_W-1:0] key_byte,
	input  logic                       key_last,
	input  logic                       ks_valid,
	input  logic                       ks_stall,
	input  logic [rc4_pkg::BYTE_W-1:0] keystream_byte,
	output int unsigned                fail_cnt,
	output int unsigned                pending_cnt,
	output int unsigned                bytes_checked
);
	import rc4_pkg::*;
	import rc4_kg_tb_pkg::*;

	logic [BYTE_W-1:0] sbox [PERM_DEPTH];
	logic [BYTE_W-1:0] key_mem [PERM_DEPTH];
	int unsigned       key_cnt;
	int unsigned       kpos;
	int unsigned       sched_len;
	logic [BYTE_W-1:0] idx_i;
	logic [BYTE_W-1:0] idx_j;
	logic [BYTE_W-1:0] acc;
	logic [BYTE_W-1:0] swap_tmp;
	logic [BYTE_W-1:0] want;
	logic [BYTE_W-1:0] keystream_due [$];
	int unsigned       fails;
	int unsigned       checked;

	function automatic void set_identity();
		for (int n = 0; n < PERM_DEPTH; n++)
			sbox[n] = BYTE_W'(n);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_identity();
			key_cnt = 0;
			idx_i = '0;
			idx_j = '0;
			keystream_due.delete();
			fails = 0;
			checked = 0;
			fail_cnt <= 0;
			pending_cnt <= 0;
			bytes_checked <= 0;
		end else begin
			if (ks_valid && !ks_stall) begin
				if (keystream_due.size() == 0) begin
					fails++;
					$display("%0t: unexpected keystream word, expected none, actual %02h",
						$time, keystream_byte);
				end else begin
					want = keystream_due.pop_front();
					checked++;
					if (keystream_byte !== want) begin
						fails++;
						$display("%0t: keystream_byte mismatch, expected %02h, actual %02h",
							$time, want, keystream_byte);
					end
				end
			end
			if (req_valid && !req_stall) begin
				if (mode == MODE_GEN) begin
					idx_i = idx_i + 8'd1;
					idx_j = idx_j + sbox[idx_i];
					swap_tmp = sbox[idx_i];
					sbox[idx_i] = sbox[idx_j];
					sbox[idx_j] = swap_tmp;
					keystream_due.push_back(sbox[BYTE_W'(sbox[idx_i] + sbox[idx_j])]);
				end else begin
					// bytes past KEY_MAX are dropped, key_last still schedules
					if (key_cnt < KEY_MAX && key_cnt < PERM_DEPTH) begin
						key_mem[key_cnt] = key_byte;
						key_cnt++;
					end
					if (key_last) begin
						sched_len = (key_cnt == 0) ? 1 : key_cnt;
						set_identity();
						acc = '0;
						kpos = 0;
						for (int n = 0; n < PERM_DEPTH; n++) begin
							acc = acc + sbox[n] + key_mem[kpos];
							swap_tmp = sbox[n];
							sbox[n] = sbox[acc];
							sbox[acc] = swap_tmp;
							kpos++;
							if (kpos >= sched_len)
								kpos = 0;
						end
						idx_i = '0;
						idx_j = '0;
						key_cnt = 0;
					end
				end
			end
			fail_cnt <= fails;
			pending_cnt <= keystream_due.size();
			bytes_checked <= checked;
		end
	end

endmodule

>>> tb/rc4_keystream_generator_core_tb.sv
// Testbench top for rc4_keystream_generator_core: drives key loads and keystream
// requests in bursts, stalls the result side, and reports the verdict.
// Depends on rc4_pkg, rc4_kg_tb_pkg and rc4_keystream_generator_core_checker.
`timescale 1ns / 100ps

module rc4_keystream_generator_core_tb;
	import rc4_pkg::*;
	import rc4_kg_tb_pkg::*;

	localparam int unsigned IDLE_LIMIT   = 5000;
	localparam int unsigned ITEMS_TARGET = 1625;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              req_valid = 1'b0;
	logic              req_stall;
	logic              mode = MODE_LOAD;
	logic [BYTE_W-1:0] key_byte = '0;
	logic              key_last = 1'b0;
	logic              ks_valid;
	logic              ks_stall = 1'b0;
	logic [BYTE_W-1:0] keystream_byte;

	int unsigned fail_cnt;
	int unsigned pending_cnt;
	int unsigned bytes_checked;
	int unsigned words_sent = 0;
	int unsigned keys_sent = 0;
	int unsigned burst_left = 0;
	int unsigned idle_cycles = 0;
	int unsigned stall_tick = 0;
	int unsigned stall_style = 0;
	int unsigned stall_hold = 0;

	always #5 clk = ~clk;

	rc4_keystream_generator_core dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.mode           (mode),
		.key_byte       (key_byte),
		.key_last       (key_last),
		.ks_valid       (ks_valid),
		.ks_stall       (ks_stall),
		.keystream_byte (keystream_byte)
	);

	rc4_keystream_generator_core_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.req_valid      (req_valid),
		.req_stall      (req_stall),
		.mode           (mode),
		.key_byte       (key_byte),
		.key_last       (key_last),
		.ks_valid       (ks_valid),
		.ks_stall       (ks_stall),
		.keystream_byte (keystream_byte),
		.fail_cnt       (fail_cnt),
		.pending_cnt    (pending_cnt),
		.bytes_checked  (bytes_checked)
	);

	// result-side stall: free-running, steady-random or long toggling runs
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1;
		if (stall_tick % 300 == 0)
			stall_style <= $urandom_range(0, 2);
		case (stall_style)
			0: begin
				ks_stall <= 1'b0;
			end
			1: begin
				ks_stall <= 1'($urandom);
			end
			default: begin
				if (stall_hold != 0) begin
					stall_hold <= stall_hold - 1;
				end else begin
					ks_stall <= ~ks_stall;
					stall_hold <= $urandom_range(0, 7);
				end
			end
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (ks_valid && !ks_stall)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("%0t: no word accepted for %0d cycles", $time, IDLE_LIMIT);
				$display("rc4_keystream_generator_core_tb NOT OK");
				$finish;
			end
		end
	end

	task automatic send_word(input logic m, input logic [BYTE_W-1:0] kb, input logic kl);
		int unsigned gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 10);
			if (gap != 0) begin
				req_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		req_valid <= 1'b1;
		mode <= m;
		key_byte <= kb;
		key_last <= kl;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		burst_left--;
		words_sent++;
		if (m == MODE_LOAD && kl)
			keys_sent++;
	endtask

	task automatic wait_drain();
		req_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_cnt != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [BYTE_W-1:0] test_key [8];
		int unsigned seq;
		int unsigned pick;
		int unsigned key_len;
		arst_n <= 1'b0;
		test_key = '{8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hAB, 8'hCD, 8'hEF};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// identity permutation, unused fields set
		repeat (3) send_word(MODE_GEN, 8'hFF, 1'b1);
		// single zero byte key
		send_word(MODE_LOAD, 8'h00, 1'b1);
		repeat (2) send_word(MODE_GEN, 8'h00, 1'b0);
		// zero bytes inside a key do not end it
		send_word(MODE_LOAD, 8'h00, 1'b0);
		send_word(MODE_LOAD, 8'hFF, 1'b0);
		send_word(MODE_LOAD, 8'h00, 1'b0);
		send_word(MODE_LOAD, 8'h80, 1'b1);
		repeat (2) send_word(MODE_GEN, 8'hAA, 1'b1);
		for (int k = 0; k < 8; k++)
			send_word(MODE_LOAD, test_key[k], k == 7);
		repeat (3) send_word(MODE_GEN, 8'($urandom), 1'($urandom));

		seq = 0;
		while (words_sent < ITEMS_TARGET) begin
			pick = $urandom_range(0, 99);
			if (seq == 3)
				key_len = 256;
			else if (seq == 7)
				key_len = 300;
			else if (pick < 5)
				key_len = $urandom_range(200, 300);
			else
				key_len = $urandom_range(1, 16);
			if (pick >= 85 && seq > 7) begin
				// noise: mixed modes, loads left open, occasional key_last
				repeat ($urandom_range(1, 30))
					send_word(1'($urandom), 8'($urandom), $urandom_range(0, 7) == 0);
			end else begin
				for (int k = 1; k <= key_len; k++)
					send_word(MODE_LOAD, 8'($urandom), k == key_len);
				repeat ($urandom_range(1, 40))
					send_word(MODE_GEN, 8'($urandom), 1'($urandom));
			end
			if (seq == 5 || $urandom_range(0, 9) == 0)
				wait_drain();
			seq++;
		end
		repeat (10) send_word(MODE_GEN, 8'($urandom), 1'($urandom));

		req_valid <= 1'b0;
		@(posedge clk);
		while (pending_cnt != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d words with %0d key schedules (keys of 1 to 300 bytes);",
			words_sent, keys_sent);
		$display("checked %0d keystream words under bursty input and stalled output.",
			bytes_checked);
		if (fail_cnt == 0 && pending_cnt == 0) begin
			$display("rc4_keystream_generator_core_tb OK");
		end else begin
			$display("rc4_keystream_generator_core_tb NOT OK");
		end
		$finish;
	end

endmodule

>>> rc4_keystream_generator_core.f
+incdir+rtl
rtl/rc4_pkg.sv
rtl/rc4_ram.sv
rtl/rc4_keystream_generator_core.sv
rtl/rc4_chk.sv
tb/rc4_keystream_generator_core_checker.sv
tb/rc4_keystream_generator_core_tb.sv
